// File: rtl/core/bli_pkg.sv
// Shared types, constants and the interpolation weight table for the bicubic interpolator.
package bli_pkg;

    localparam int SAMPLE_BITS      = 16;
    localparam int COORD_FRAC_BITS  = 8;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int COORD_BITS       = 17;
    localparam int CFG_BITS         = 9;
    localparam int W_BITS           = 18;
    localparam int LIN_BITS         = 21;
    localparam int PROD_BITS        = W_BITS + SAMPLE_BITS + 1;
    localparam int ROW_BITS         = PROD_BITS + 2;
    localparam int YPROD_BITS       = W_BITS + ROW_BITS;
    localparam int ACC_BITS         = YPROD_BITS + 2;
    localparam int OUT_BITS         = 18;
    localparam int RND_BITS         = ACC_BITS - 2 * WEIGHT_FRAC_BITS;
    localparam int OUT_LOW_MAG      = 65536;
    localparam int OUT_HIGH         = 131071;
    localparam int FRAC_ONE         = 1 << COORD_FRAC_BITS;
    localparam int W_SHIFT          = 3 * COORD_FRAC_BITS - WEIGHT_FRAC_BITS;
    localparam longint W_DIV6       = longint'(6) << W_SHIFT;
    localparam longint W_DIV2       = longint'(2) << W_SHIFT;
    localparam longint W_ONE        = longint'(1) << WEIGHT_FRAC_BITS;

    typedef logic signed [W_BITS-1:0] t_weight;
    typedef t_weight [3:0] t_wset;
    typedef t_wset [FRAC_ONE-1:0] t_wtab;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_BOUND,
        ST_READ,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic write;
        logic capture;
        logic check;
        logic bound;
        logic issue;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_window;
        logic last_issue;
        logic done;
        logic out_free;
    } t_sts;

    // Lagrange weights for nodes -1,0,1,2 at every coordinate fraction.
    // The node 0 weight takes up the rounding so each set sums to one.
    function automatic t_wtab build_wtab();
        t_wtab  tab;
        longint num;
        longint mag;
        longint q;
        longint w;
        longint w0;
        bit     neg;
        for (int u = 0; u < FRAC_ONE; u++) begin
            w0 = W_ONE;
            for (int k = -1; k <= 2; k++) begin
                if (k != 0) begin
                    num = 1;
                    for (int j = -1; j <= 2; j++) begin
                        if (j != k) begin
                            num = num * (longint'(u) - longint'(j) * FRAC_ONE);
                        end
                    end
                    mag = (num < 0) ? -num : num;
                    if (k == 1) begin
                        q = (mag + W_DIV2 / 2) / W_DIV2;
                    end else begin
                        q = (mag + W_DIV6 / 2) / W_DIV6;
                    end
                    // denominator is negative for nodes -1 and 1
                    neg = (num < 0) ^ (k != 2);
                    w = neg ? -q : q;
                    tab[u][k+1] = W_BITS'(w);
                    w0 = w0 - w;
                end
            end
            tab[u][1] = W_BITS'(w0);
        end
        return tab;
    endfunction

    localparam t_wtab WTAB = build_wtab();

    // Round to nearest (ties away from zero) and saturate to the output range.
    function automatic logic [OUT_BITS-1:0] round_sat(logic signed [ACC_BITS-1:0] a);
        logic                neg;
        logic [ACC_BITS-1:0] mag;
        logic [ACC_BITS-1:0] tmp;
        logic [RND_BITS-1:0] rnd;
        logic [OUT_BITS-1:0] res;
        neg = a[ACC_BITS-1];
        mag = neg ? (ACC_BITS'(0) - ACC_BITS'(a)) : ACC_BITS'(a);
        tmp = mag + (ACC_BITS'(1) << (2 * WEIGHT_FRAC_BITS - 1));
        rnd = tmp[ACC_BITS-1:2*WEIGHT_FRAC_BITS];
        if (neg) begin
            if (rnd > RND_BITS'(OUT_LOW_MAG)) begin
                res = OUT_BITS'(RND_BITS'(0) - RND_BITS'(OUT_LOW_MAG));
            end else begin
                res = OUT_BITS'(RND_BITS'(0) - rnd);
            end
        end else begin
            if (rnd > RND_BITS'(OUT_HIGH)) begin
                res = OUT_BITS'(OUT_HIGH);
            end else begin
                res = OUT_BITS'(rnd);
            end
        end
        return res;
    endfunction

endpackage

// File: rtl/core/bicubic_lagrange_interpolator.sv
// Top level: 4x4 bicubic Lagrange interpolator over a stored RGB sample grid.
// Write items: no result, accepted back to back. Queries run one at a time.
// Inside query: window check, 16 reads from the single store read port, then pipeline
// drain and output load; the next item is taken once the result is loaded.
// Outside query: window check only, no store reads. Output stalls delay the result load.
// Sync active-low reset clears control, grid 256 x 256; store undefined until written.
module bicubic_lagrange_interpolator #(
    parameter int MAX_SAMPLES = 65536
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_command,
    input  logic [15:0]                           i_sample_index,
    input  logic [15:0]                           i_sample_red,
    input  logic [15:0]                           i_sample_green,
    input  logic [15:0]                           i_sample_blue,
    input  logic signed [bli_pkg::COORD_BITS-1:0] i_query_x,
    input  logic signed [bli_pkg::COORD_BITS-1:0] i_query_y,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [bli_pkg::OUT_BITS-1:0]   o_out_red,
    output logic signed [bli_pkg::OUT_BITS-1:0]   o_out_green,
    output logic signed [bli_pkg::OUT_BITS-1:0]   o_out_blue,
    output logic                                  o_inside_res,
    input  logic                                  i_cfg_we,
    input  logic [1:0]                            i_cfg_index,
    input  logic [bli_pkg::CFG_BITS-1:0]          i_cfg_data
);
    import bli_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    bli_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_command  (i_command),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bli_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_sample_index (i_sample_index),
        .i_sample_red   (i_sample_red),
        .i_sample_green (i_sample_green),
        .i_sample_blue  (i_sample_blue),
        .i_query_x      (i_query_x),
        .i_query_y      (i_query_y),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue),
        .o_inside_res   (o_inside_res)
    );

`ifndef SYNTHESIS
    // a result is only loaded when the output register can take it
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> w_sts.out_free)
        else $error("result loaded over a pending item");

    // no new item is taken while store reads are in progress
    a_busy_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.issue |-> !o_in_ready)
        else $error("input ready during window reads");

    // an outside result carries zero channels
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_inside_res) |->
            (o_out_red == '0 && o_out_green == '0 && o_out_blue == '0))
        else $error("outside result with nonzero channels");
`endif

endmodule

// File: rtl/core/bli_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bli_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/bli_ctrl.sv
// Sequencer for write and query items of the bicubic interpolator.
module bli_ctrl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic         i_command,
    input  bli_pkg::t_sts i_sts,
    output bli_pkg::t_cmd o_cmd
);
    import bli_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_command == CMD_QUERY) begin
                        o_cmd.capture = 1'b1;
                        n_state       = ST_CHECK;
                    end else begin
                        o_cmd.write = 1'b1;
                    end
                end
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = ST_BOUND;
            end
            ST_BOUND: begin
                o_cmd.bound = 1'b1;
                n_state     = i_sts.in_window ? ST_READ : ST_FINISH;
            end
            ST_READ: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_sts.done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/bli_datapath.sv
// Sample store, window check, weight lookup and multiply-accumulate pipeline.
module bli_datapath #(
    parameter int MAX_SAMPLES = 65536
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  bli_pkg::t_cmd                          i_cmd,
    output bli_pkg::t_sts                          o_sts,
    input  logic                                   i_cfg_we,
    input  logic [1:0]                             i_cfg_index,
    input  logic [bli_pkg::CFG_BITS-1:0]           i_cfg_data,
    input  logic [15:0]                            i_sample_index,
    input  logic [15:0]                            i_sample_red,
    input  logic [15:0]                            i_sample_green,
    input  logic [15:0]                            i_sample_blue,
    input  logic signed [bli_pkg::COORD_BITS-1:0]  i_query_x,
    input  logic signed [bli_pkg::COORD_BITS-1:0]  i_query_y,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [bli_pkg::OUT_BITS-1:0]    o_out_red,
    output logic signed [bli_pkg::OUT_BITS-1:0]    o_out_green,
    output logic signed [bli_pkg::OUT_BITS-1:0]    o_out_blue,
    output logic                                   o_inside_res
);
    import bli_pkg::*;

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int IW = COORD_BITS - COORD_FRAC_BITS;

    // configuration
    logic [CFG_BITS-1:0] r_grid_w;
    logic [CFG_BITS-1:0] r_grid_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= CFG_BITS'(256);
            r_grid_h <= CFG_BITS'(256);
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_WIDTH) begin
                r_grid_w <= i_cfg_data;
            end else if (i_cfg_index == REG_HEIGHT) begin
                r_grid_h <= i_cfg_data;
            end
        end
    end

    // sample store
    logic                     w_we;
    logic [AW-1:0]            w_raddr;
    logic [3*SAMPLE_BITS-1:0] w_rdata;

    assign w_we = i_cmd.write &&
                  (LIN_BITS'(i_sample_index) < LIN_BITS'(MAX_SAMPLES));

    bli_ram #(
        .WIDTH (3 * SAMPLE_BITS),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_sample_index)),
        .i_wdata ({SAMPLE_BITS'(i_sample_red), SAMPLE_BITS'(i_sample_green),
                   SAMPLE_BITS'(i_sample_blue)}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // query capture
    logic signed [COORD_BITS-1:0] r_qx;
    logic signed [COORD_BITS-1:0] r_qy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_qx <= i_query_x;
            r_qy <= i_query_y;
        end
    end

    // window corner = floor - 1; bounds against the grid
    logic signed [IW:0]  w_ix;
    logic signed [IW:0]  w_iy;
    logic                w_x_ok;
    logic                w_y_ok;
    logic [LIN_BITS-1:0] w_base;

    assign w_ix   = {r_qx[COORD_BITS-1], r_qx[COORD_BITS-1:COORD_FRAC_BITS]} - (IW+1)'(1);
    assign w_iy   = {r_qy[COORD_BITS-1], r_qy[COORD_BITS-1:COORD_FRAC_BITS]} - (IW+1)'(1);
    assign w_x_ok = !w_ix[IW] &&
                    (LIN_BITS'(w_ix[IW-1:0]) + LIN_BITS'(3) < LIN_BITS'(r_grid_w));
    assign w_y_ok = !w_iy[IW] &&
                    (LIN_BITS'(w_iy[IW-1:0]) + LIN_BITS'(3) < LIN_BITS'(r_grid_h));
    assign w_base = LIN_BITS'(w_iy[IW-1:0]) * LIN_BITS'(r_grid_w) +
                    LIN_BITS'(w_ix[IW-1:0]);

    logic [LIN_BITS-1:0] r_base;
    logic                r_win_ok;
    t_wset               r_wx;
    t_wset               r_wy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_base   <= w_base;
            r_win_ok <= w_x_ok && w_y_ok;
            r_wx     <= WTAB[r_qx[COORD_FRAC_BITS-1:0]];
            r_wy     <= WTAB[r_qy[COORD_FRAC_BITS-1:0]];
        end
    end

    // last window address must also lie in the store
    logic [LIN_BITS-1:0] w_last;
    logic                w_inside_now;
    logic                r_inside;

    assign w_last       = r_base + LIN_BITS'({r_grid_w, 1'b0}) + LIN_BITS'(r_grid_w) +
                          LIN_BITS'(3);
    assign w_inside_now = r_win_ok && (w_last < LIN_BITS'(MAX_SAMPLES));

    // read address walk: four columns, then step one row
    logic [LIN_BITS-1:0] r_rowbase;
    logic [1:0]          r_k;
    logic [1:0]          r_r;

    always_ff @(posedge i_clk) begin
        if (i_cmd.bound) begin
            r_inside  <= w_inside_now;
            r_rowbase <= r_base;
            r_k       <= 2'd0;
            r_r       <= 2'd0;
        end else if (i_cmd.issue) begin
            r_k <= r_k + 2'd1;
            if (r_k == 2'd3) begin
                r_rowbase <= r_rowbase + LIN_BITS'(r_grid_w);
                r_r       <= r_r + 2'd1;
            end
        end
    end

    assign w_raddr = AW'(r_rowbase + LIN_BITS'(r_k));

    // MAC pipeline: sample x column weight, row sum, row x row weight, sum
    logic                          r_v1, r_v2, r_v3, r_v4, r_done;
    logic [1:0]                    r_k1, r_r1, r_k2, r_r2, r_r3, r_r4;
    logic signed [PROD_BITS-1:0]   r_prod  [3];
    logic signed [ROW_BITS-1:0]    r_row   [3];
    logic signed [YPROD_BITS-1:0]  r_yprod [3];
    logic signed [ACC_BITS-1:0]    r_acc   [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_cmd.issue;
            r_v2   <= r_v1;
            r_v3   <= r_v2 && (r_k2 == 2'd3);
            r_v4   <= r_v3;
            r_done <= r_v4 && (r_r4 == 2'd3);
        end
    end

    always_ff @(posedge i_clk) begin
        r_k1 <= r_k;
        r_r1 <= r_r;
        r_k2 <= r_k1;
        r_r2 <= r_r1;
        r_r3 <= r_r2;
        r_r4 <= r_r3;
        for (int c = 0; c < 3; c++) begin
            if (r_v1) begin
                r_prod[c] <= r_wx[r_k1] *
                             $signed({1'b0, w_rdata[(2-c)*SAMPLE_BITS +: SAMPLE_BITS]});
            end
            if (r_v2) begin
                if (r_k2 == 2'd0) begin
                    r_row[c] <= ROW_BITS'(r_prod[c]);
                end else begin
                    r_row[c] <= r_row[c] + ROW_BITS'(r_prod[c]);
                end
            end
            if (r_v3) begin
                r_yprod[c] <= r_wy[r_r3] * r_row[c];
            end
            if (r_v4) begin
                if (r_r4 == 2'd0) begin
                    r_acc[c] <= ACC_BITS'(r_yprod[c]);
                end else begin
                    r_acc[c] <= r_acc[c] + ACC_BITS'(r_yprod[c]);
                end
            end
        end
    end

    // output register
    logic                r_ovalid;
    logic [OUT_BITS-1:0] r_ored, r_ogreen, r_oblue;
    logic                r_oinside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_oinside <= r_inside;
            r_ored    <= r_inside ? round_sat(r_acc[0]) : '0;
            r_ogreen  <= r_inside ? round_sat(r_acc[1]) : '0;
            r_oblue   <= r_inside ? round_sat(r_acc[2]) : '0;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_out_red    = $signed(r_ored);
    assign o_out_green  = $signed(r_ogreen);
    assign o_out_blue   = $signed(r_oblue);
    assign o_inside_res = r_oinside;

    assign o_sts.in_window  = w_inside_now;
    assign o_sts.last_issue = (r_k == 2'd3) && (r_r == 2'd3);
    assign o_sts.done       = r_done;
    assign o_sts.out_free   = !r_ovalid || i_out_ready;

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the bicubic Lagrange interpolator: grid writes, queries, config.
module testbench;
    import bli_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic signed [OUT_BITS-1:0] red;
        logic signed [OUT_BITS-1:0] green;
        logic signed [OUT_BITS-1:0] blue;
        logic                       in_grid;
    } t_pixel;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic                          i_command;
    logic [15:0]                   i_sample_index;
    logic [15:0]                   i_sample_red;
    logic [15:0]                   i_sample_green;
    logic [15:0]                   i_sample_blue;
    logic signed [COORD_BITS-1:0]  i_query_x;
    logic signed [COORD_BITS-1:0]  i_query_y;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic signed [OUT_BITS-1:0]    o_out_red;
    logic signed [OUT_BITS-1:0]    o_out_green;
    logic signed [OUT_BITS-1:0]    o_out_blue;
    logic                          o_inside_res;
    logic                          i_cfg_we;
    logic [1:0]                    i_cfg_index;
    logic [CFG_BITS-1:0]           i_cfg_data;

    // shadow of the sample grid and the geometry
    logic [47:0] grid_mem [0:65535];
    bit          grid_known [0:65535];
    int          grid_w;
    int          grid_h;

    t_pixel pending_pix[$];
    int     errors;
    int     cycles;
    int     n_writes;
    int     n_queries;
    int     n_inside;
    int     n_checked;
    bit     steady;
    int     hold_req;

    bicubic_lagrange_interpolator dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Lagrange weight of node k at fraction u, Q16, ties away from zero
    function automatic longint node_weight(int u, int k);
        longint num;
        longint den;
        longint mag;
        longint dm;
        longint q;
        num = 1;
        den = 1;
        for (int j = -1; j <= 2; j++) begin
            if (j != k) begin
                num = num * (longint'(u) - longint'(j) * FRAC_ONE);
                den = den * (k - j);
            end
        end
        mag = (num < 0) ? -num : num;
        dm  = ((den < 0) ? -den : den) << 8;
        q   = (mag + dm / 2) / dm;
        return (((num < 0) != (den < 0)) ? -q : q);
    endfunction

    function automatic logic signed [OUT_BITS-1:0] to_pixel(longint acc);
        longint mag;
        longint r;
        mag = (acc < 0) ? -acc : acc;
        r   = (mag + (longint'(1) << 31)) >> 32;
        if (acc < 0) begin
            return OUT_BITS'((r > 65536) ? -65536 : -r);
        end else begin
            return OUT_BITS'((r > 131071) ? 131071 : r);
        end
    endfunction

    // expected result of one query against the shadow grid
    function automatic t_pixel interpolate(logic signed [16:0] qx, logic signed [16:0] qy);
        t_pixel p;
        int     fx;
        int     fy;
        int     i0;
        int     j0;
        longint wx[4];
        longint wy[4];
        longint acc;
        longint row;
        int     addr;
        fx = qx >>> 8;
        fy = qy >>> 8;
        i0 = fx - 1;
        j0 = fy - 1;
        p = '{0, 0, 0, 1'b0};
        if (i0 < 0 || i0 + 3 >= grid_w || j0 < 0 || j0 + 3 >= grid_h ||
            (j0 + 3) * grid_w + i0 + 3 >= 65536) begin
            return p;
        end
        for (int n = 0; n < 4; n++) begin
            if (n != 1) begin
                wx[n] = node_weight(int'(qx[7:0]), n - 1);
                wy[n] = node_weight(int'(qy[7:0]), n - 1);
            end
        end
        wx[1] = 65536 - wx[0] - wx[2] - wx[3];
        wy[1] = 65536 - wy[0] - wy[2] - wy[3];
        for (int c = 0; c < 3; c++) begin
            acc = 0;
            for (int r = 0; r < 4; r++) begin
                row = 0;
                for (int k = 0; k < 4; k++) begin
                    addr = (j0 + r) * grid_w + i0 + k;
                    row += wx[k] * longint'(grid_mem[addr][16*c +: 16]);
                end
                acc += wy[r] * row;
            end
            if (c == 0) p.red = to_pixel(acc);
            else if (c == 1) p.green = to_pixel(acc);
            else p.blue = to_pixel(acc);
        end
        p.in_grid = 1'b1;
        return p;
    endfunction

    // offer one item, hold it until taken, then record what it should produce
    task automatic send_item(t_op op, logic [15:0] idx, logic [47:0] rgb,
                             logic signed [16:0] qx, logic signed [16:0] qy);
        t_pixel p;
        while (!steady && $urandom_range(99) < 32) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= op;
        i_sample_index <= idx;
        i_sample_red   <= rgb[15:0];
        i_sample_green <= rgb[31:16];
        i_sample_blue  <= rgb[47:32];
        i_query_x      <= qx;
        i_query_y      <= qy;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (op == CMD_WRITE) begin
            grid_mem[idx]   = rgb;
            grid_known[idx] = 1'b1;
            n_writes++;
        end else begin
            p = interpolate(qx, qy);
            pending_pix = {pending_pix, p};
            n_queries++;
            if (p.in_grid) n_inside++;
        end
    endtask

    task automatic write_sample(int idx, logic [47:0] rgb);
        send_item(CMD_WRITE, 16'(idx), rgb, '0, '0);
    endtask

    // query at whole position + fraction; fills unwritten entries of an in-grid window first
    task automatic query_at(int fx, int fy, int ux, int uy);
        int addr;
        if (fx >= 1 && fx + 2 < grid_w && fy >= 1 && fy + 2 < grid_h) begin
            for (int r = -1; r <= 2; r++) begin
                for (int k = -1; k <= 2; k++) begin
                    addr = (fy + r) * grid_w + fx + k;
                    if (!grid_known[addr]) write_sample(addr, 48'({$urandom, $urandom}));
                end
            end
        end
        send_item(CMD_QUERY, '0, '0, 17'(fx * FRAC_ONE + ux), 17'(fy * FRAC_ONE + uy));
    endtask

    // raw coordinates; split so that a window inside the grid is filled first
    task automatic query_raw(logic signed [16:0] qx, logic signed [16:0] qy);
        int fx;
        int fy;
        fx = qx >>> 8;
        fy = qy >>> 8;
        query_at(fx, fy, int'(qx[7:0]), int'(qy[7:0]));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pix.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // geometry changes only while the block is idle
    task automatic set_grid(int w, int h);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_WIDTH;
        i_cfg_data  <= CFG_BITS'(w);
        @(posedge i_clk);
        i_cfg_index <= REG_HEIGHT;
        i_cfg_data  <= CFG_BITS'(h);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        grid_w = w;
        grid_h = h;
    endtask

    task automatic test_directed();
        // full-scale checkerboard drives the weights to overshoot
        for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 4; k++) begin
                write_sample(r * grid_w + k, ((r + k) % 2) ? 48'hFFFF_FFFF_FFFF : 48'h0);
            end
        end
        query_at(1, 1, 0, 0);
        query_at(1, 1, 8'h80, 8'h80);
        query_at(1, 1, 8'hFF, 8'hFF);
        query_at(1, 1, 8'h01, 8'hFE);
        query_at(253, 253, 8'hFF, 8'h00);
        query_raw(-17'sd65536, -17'sd65536);
        query_raw(17'sd65535, 17'sd65535);
        query_raw(17'sh000FF, 17'sh00100);
        query_at(254, 1, 0, 0);
        query_at(1, 254, 0, 0);
    endtask

    task automatic test_geometry();
        set_grid(1, 1);
        query_raw(17'sh00100, 17'sh00100);
        query_raw($urandom, $urandom);
        set_grid(4, 4);
        for (int n = 0; n < 4; n++) query_at(1, 1, $urandom_range(255), $urandom_range(255));
        query_at(2, 1, 0, 0);
        set_grid(256, 4);
        query_at(200, 1, $urandom_range(255), $urandom_range(255));
        set_grid(4, 256);
        query_at(1, 250, $urandom_range(255), $urandom_range(255));
        // a write to an unused register index must leave the geometry alone
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_SPARE;
        i_cfg_data  <= CFG_BITS'(3);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        query_at(1, 200, 8'h40, 8'hC0);
    endtask

    // inside queries stay near the grid corner so window fills are shared
    task automatic test_random(int count);
        int sel;
        for (int n = 0; n < count; n++) begin
            if (n % 90 == 0) set_grid($urandom_range(4, 256), $urandom_range(4, 64));
            steady = (n % 90 >= 50 && n % 90 < 75);
            sel = $urandom_range(99);
            if (sel < 65) begin
                query_at($urandom_range(1, (grid_w - 3 < 4) ? grid_w - 3 : 4),
                         $urandom_range(1, (grid_h - 3 < 4) ? grid_h - 3 : 4),
                         $urandom_range(255), $urandom_range(255));
            end else if (sel < 85) begin
                query_raw($urandom, $urandom);
            end else begin
                write_sample($urandom_range(grid_w * grid_h - 1), 48'({$urandom, $urandom}));
            end
        end
        steady = 1'b0;
    endtask

    // receiver stalls long enough to back the block up into its input
    task automatic test_backpressure();
        set_grid(16, 16);
        hold_req = 300;
        for (int n = 0; n < 12; n++) query_at($urandom_range(1, 4), $urandom_range(1, 4),
                                             $urandom_range(255), $urandom_range(255));
        wait_drained();
        for (int n = 0; n < 6; n++) query_at($urandom_range(1, 4), $urandom_range(1, 4),
                                            $urandom_range(255), $urandom_range(255));
    endtask

    task automatic test_full_grid();
        set_grid(256, 256);
        for (int n = 0; n < 4; n++) query_at($urandom_range(1, 253), $urandom_range(1, 253),
                                            $urandom_range(255), $urandom_range(255));
    endtask

    // receiver: random stalls, long hold when asked, none while steady
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                i_out_ready <= 1'b0;
                hold_req--;
            end else begin
                i_out_ready <= steady || ($urandom_range(99) >= 32);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pix.size() == 0) begin
                $display("%0t: unexpected result red=%0d green=%0d blue=%0d inside=%0b",
                         $time, o_out_red, o_out_green, o_out_blue, o_inside_res);
                errors++;
            end else begin
                want = pending_pix.pop_front();
                n_checked++;
                if (want.red !== o_out_red || want.green !== o_out_green ||
                    want.blue !== o_out_blue || want.in_grid !== o_inside_res) begin
                    $display("%0t: mismatch exp r=%0d g=%0d b=%0d in=%0b got r=%0d g=%0d b=%0d in=%0b",
                             $time, want.red, want.green, want.blue, want.in_grid,
                             o_out_red, o_out_green, o_out_blue, o_inside_res);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        errors = 0; cycles = 0; n_writes = 0; n_queries = 0; n_inside = 0; n_checked = 0;
        steady = 1'b0; hold_req = 0;
        grid_w = 256; grid_h = 256;
        for (int n = 0; n < 65536; n++) grid_known[n] = 1'b0;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_command = CMD_WRITE;
        i_sample_index = '0; i_sample_red = '0; i_sample_green = '0; i_sample_blue = '0;
        i_query_x = '0; i_query_y = '0;
        i_cfg_we = 1'b0; i_cfg_index = REG_WIDTH; i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_geometry();
        test_random(160);
        test_backpressure();
        test_full_grid();
        wait_drained();
        $display("Ran %0d queries (%0d inside the grid) and %0d sample writes; %0d results checked.",
                 n_queries, n_inside, n_writes, n_checked);
        $display("Covered grid sizes from 1x1 to 256x256, long output stalls and idle gaps.");
        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
